[sv/pbvl_pkg.sv]
// ----------------------------------------------------------------------------
// pbvl_pkg
// Shared widths and edge-mask tables for the page buffer line fill core.
// ----------------------------------------------------------------------------
package pbvl_pkg;

   localparam int COL_W   = 7;   // column field
   localparam int ROW_W   = 8;   // signed row fields
   localparam int PAT_W   = 8;   // pattern and data byte
   localparam int RADDR_W = 10;  // byte address of a read
   localparam int Y_W     = 7;   // clipped row, 0..127
   localparam int PAGE_W  = 4;   // page index, row bits above the low three
   localparam int EXT_W   = 13;  // wide enough for any byte address

   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Rows at and below the start row within a page are kept.
   function automatic logic [PAT_W-1:0] upper_keep(input logic [2:0] idx);
      logic [PAT_W-1:0] m;
      case (idx)
         3'd0: m = 8'hff;
         3'd1: m = 8'hfe;
         3'd2: m = 8'hfc;
         3'd3: m = 8'hf8;
         3'd4: m = 8'hf0;
         3'd5: m = 8'he0;
         3'd6: m = 8'hc0;
         3'd7: m = 8'h80;
         default: m = 8'hff;
      endcase
      return m;
   endfunction

   // Rows up to and including the end row within a page are kept.
   function automatic logic [PAT_W-1:0] lower_keep(input logic [2:0] idx);
      logic [PAT_W-1:0] m;
      case (idx)
         3'd0: m = 8'h01;
         3'd1: m = 8'h03;
         3'd2: m = 8'h07;
         3'd3: m = 8'h0f;
         3'd4: m = 8'h1f;
         3'd5: m = 8'h3f;
         3'd6: m = 8'h7f;
         3'd7: m = 8'hff;
         default: m = 8'hff;
      endcase
      return m;
   endfunction

endpackage

[sv/pbvl_req_if.sv]
// ----------------------------------------------------------------------------
// pbvl_req_if
// Request channel: valid/ready handshake with draw and read fields.
// ----------------------------------------------------------------------------
interface pbvl_req_if import pbvl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [COL_W-1:0]          column;
   logic signed [ROW_W-1:0]   row_start;
   logic signed [ROW_W-1:0]   row_end;
   logic [PAT_W-1:0]          fill_pattern;
   logic [RADDR_W-1:0]        read_address;

   modport source (output valid, req_type, column, row_start, row_end,
                   fill_pattern, read_address, input ready);
   modport sink   (input valid, req_type, column, row_start, row_end,
                   fill_pattern, read_address, output ready);
endinterface

[sv/pbvl_rsp_if.sv]
// ----------------------------------------------------------------------------
// pbvl_rsp_if
// Response channel: valid/ready handshake with read data and reject flag.
// ----------------------------------------------------------------------------
interface pbvl_rsp_if import pbvl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PAT_W-1:0] read_data;
   logic             draw_rejected;

   modport source (output valid, read_data, draw_rejected, input ready);
   modport sink   (input valid, read_data, draw_rejected, output ready);
endinterface

[sv/page_buffer_vertical_line_fill_core.sv]
// ----------------------------------------------------------------------------
// page_buffer_vertical_line_fill_core
// Paged monochrome framebuffer with vertical line fill and byte readback.
// ----------------------------------------------------------------------------
// The framebuffer is PAGE_COUNT pages of SCREEN_WIDTH column bytes held in a
// single-port-style RAM (one write, one registered read per cycle); bit n of
// a byte is row n of its page, byte address = page * SCREEN_WIDTH + column.
// After reset a clearing pass zeroes the RAM one byte per cycle; no request
// beat is taken until it ends. One request is worked at a time and every
// request yields exactly one response beat. A read passes the setup step,
// a registered RAM read and the done step into the response register; an
// address past the store skips the RAM and returns zero. A draw writes each
// page it covers whole straight away and reads, masks and writes back each
// edge page; the RAM port is the shared unit that all these steps use.
// A rejected draw (inverted, fully above or below the screen, or column past
// the width) writes nothing. A finished response sits in the output register,
// so the next request is accepted while it waits.
// ----------------------------------------------------------------------------
module page_buffer_vertical_line_fill_core
   import pbvl_pkg::*;
#(
   parameter int SCREEN_WIDTH = 128,
   parameter int PAGE_COUNT   = 8
) (
   input logic        clock,
   input logic        reset,
   pbvl_req_if.sink   req_ch,
   pbvl_rsp_if.source rsp_ch
);

   localparam int DEPTH = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [EXT_W-1:0]        DEPTH_EXT = EXT_W'(DEPTH);
   localparam logic [EXT_W-1:0]        WIDTH_EXT = EXT_W'(SCREEN_WIDTH);
   localparam logic [8:0]              COL_LIM   = 9'(SCREEN_WIDTH);
   localparam logic signed [ROW_W-1:0] LAST_ROW  = ROW_W'(PAGE_COUNT * 8 - 1);
   localparam logic [AW:0]             CLR_LAST  = (AW + 1)'(DEPTH - 1);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_PAGE  = 3'd3;
   localparam logic [2:0] ST_MERGE = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [AW:0] clr_cnt_ff, clr_cnt_in;

   // latched request
   logic                    type_ff;
   logic [COL_W-1:0]        col_ff;
   logic signed [ROW_W-1:0] start_ff;
   logic signed [ROW_W-1:0] end_ff;
   logic [PAT_W-1:0]        pat_ff;
   logic [RADDR_W-1:0]      raddr_ff;

   // line walk
   logic [Y_W-1:0]    y0_ff, y0_in;
   logic [Y_W-1:0]    y1_ff, y1_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [AW-1:0]     addr_ff, addr_in;

   // result held until the done step
   logic [PAT_W-1:0] res_data_ff, res_data_in;
   logic             res_rej_ff, res_rej_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PAT_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_rej_ff, rsp_rej_in;

   // frame RAM
   logic [PAT_W-1:0] frame_store [DEPTH];
   logic [PAT_W-1:0] rd_data_ff;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [PAT_W-1:0] mem_wdata;

   // setup decode
   logic             draw_bad;
   logic [Y_W-1:0]   y0_clip, y1_clip;
   logic [EXT_W-1:0] start_addr, next_addr, rd_addr_ext;
   logic             rd_in_range;

   // page mask
   logic             first_pg, last_pg;
   logic [PAT_W-1:0] mask;
   logic [PAT_W-1:0] merged;

   logic req_fire;

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign req_fire             = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.read_data     = rsp_data_ff;
   assign rsp_ch.draw_rejected = rsp_rej_ff;

   // reject: column past width, inverted, all below or all above the screen
   assign draw_bad = ({2'b00, col_ff} >= COL_LIM) || (end_ff < start_ff) ||
                     end_ff[ROW_W-1] || (start_ff > LAST_ROW);
   assign y0_clip  = start_ff[ROW_W-1] ? '0 : start_ff[Y_W-1:0];
   assign y1_clip  = (end_ff > LAST_ROW) ? LAST_ROW[Y_W-1:0] : end_ff[Y_W-1:0];

   assign start_addr  = EXT_W'(y0_clip[Y_W-1:3]) * WIDTH_EXT + EXT_W'(col_ff);
   assign next_addr   = EXT_W'(addr_ff) + WIDTH_EXT;
   assign rd_addr_ext = EXT_W'(raddr_ff);
   assign rd_in_range = rd_addr_ext < DEPTH_EXT;

   assign first_pg = (page_ff == y0_ff[Y_W-1:3]);
   assign last_pg  = (page_ff == y1_ff[Y_W-1:3]);
   assign mask     = (first_pg ? upper_keep(y0_ff[2:0]) : 8'hff) &
                     (last_pg  ? lower_keep(y1_ff[2:0]) : 8'hff);
   assign merged   = (rd_data_ff & ~mask) | (pat_ff & mask);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      page_in      = page_ff;
      addr_in      = addr_ff;
      res_data_in  = res_data_ff;
      res_rej_in   = res_rej_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_rej_in   = rsp_rej_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = addr_ff;
      mem_raddr    = addr_ff;
      mem_wdata    = pat_ff;

      case (state_ff)
         ST_CLEAR: begin
            // zero the RAM after reset
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff[AW-1:0];
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            res_data_in = '0;
            res_rej_in  = 1'b0;
            if (type_ff == REQ_READ) begin
               if (rd_in_range) begin
                  mem_re    = 1'b1;
                  mem_raddr = rd_addr_ext[AW-1:0];
                  state_in  = ST_READ;
               end else begin
                  state_in  = ST_DONE;
               end
            end else if (draw_bad) begin
               res_rej_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               y0_in    = y0_clip;
               y1_in    = y1_clip;
               page_in  = y0_clip[Y_W-1:3];
               addr_in  = start_addr[AW-1:0];
               state_in = ST_PAGE;
            end
         end
         ST_PAGE: begin
            if (mask == 8'hff) begin
               // whole page: plain overwrite, then step down a page
               mem_we = 1'b1;
               if (last_pg) begin
                  state_in = ST_DONE;
               end else begin
                  page_in = page_ff + 1'b1;
                  addr_in = next_addr[AW-1:0];
               end
            end else begin
               // edge page: fetch the byte for a masked merge
               mem_re   = 1'b1;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            mem_we    = 1'b1;
            mem_wdata = merged;
            if (last_pg) begin
               state_in = ST_DONE;
            end else begin
               page_in  = page_ff + 1'b1;
               addr_in  = next_addr[AW-1:0];
               state_in = ST_PAGE;
            end
         end
         ST_READ: begin
            res_data_in = rd_data_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_rej_in   = res_rej_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff  <= req_ch.req_type;
         col_ff   <= req_ch.column;
         start_ff <= req_ch.row_start;
         end_ff   <= req_ch.row_end;
         pat_ff   <= req_ch.fill_pattern;
         raddr_ff <= req_ch.read_address;
      end
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      page_ff     <= page_in;
      addr_ff     <= addr_in;
      res_data_ff <= res_data_in;
      res_rej_ff  <= res_rej_in;
      rsp_data_ff <= rsp_data_in;
      rsp_rej_ff  <= rsp_rej_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= frame_store[mem_raddr];
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the paged framebuffer vertical line fill core.
// ----------------------------------------------------------------------------
// A mirror of the framebuffer is kept alongside the core. Every accepted
// request beat updates the mirror and queues the reply beat it should give.
// Every reply beat is checked against the oldest queued one. Stimulus is a
// short directed sweep of edge rows, clipping and refused draws, followed by
// a long random mix of draws and readbacks. Both handshake sides idle at
// random, and one long reply hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module testbench;
   import pbvl_pkg::*;

   localparam int SCREEN_WIDTH = 128;
   localparam int PAGE_COUNT   = 8;
   localparam int STORE_DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
   localparam int LAST_ROW     = PAGE_COUNT * 8 - 1;
   localparam int RANDOM_BEATS = 1900;
   // clearing pass plus about 2000 beats at their slowest, several times over
   localparam int CYCLE_LIMIT  = 400000;

   // -------------------------------------------------------------------------
   // Framebuffer mirror: predicts reply beats and checks the ones that arrive.
   // -------------------------------------------------------------------------
   class framebuffer_mirror;
      typedef struct packed {
         logic [PAT_W-1:0] read_data;
         logic             draw_rejected;
      } reply_type;

      logic [PAT_W-1:0] pixels [STORE_DEPTH];
      reply_type        pending_replies [$];
      int               mismatches;
      int               checked;
      int               draws;
      int               refused;
      int               reads;
      int               lit_reads;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         mismatches = 0;
         checked    = 0;
         draws      = 0;
         refused    = 0;
         reads      = 0;
         lit_reads  = 0;
      endfunction

      // Apply one accepted request to the mirror and queue its reply.
      function void apply_request(input logic kind,
                                  input logic [COL_W-1:0] column,
                                  input logic signed [ROW_W-1:0] row_start,
                                  input logic signed [ROW_W-1:0] row_end,
                                  input logic [PAT_W-1:0] pattern,
                                  input logic [RADDR_W-1:0] address);
         reply_type        want;
         int               first_row;
         int               last_row;
         int               y0;
         int               y1;
         int               pg;
         int               idx;
         logic [PAT_W-1:0] mask;
         want      = '0;
         first_row = row_start;
         last_row  = row_end;
         if (kind == REQ_READ) begin
            reads++;
            if (address < STORE_DEPTH) want.read_data = pixels[address];
            if (want.read_data != 0) lit_reads++;
         end else begin
            draws++;
            if (column >= SCREEN_WIDTH || last_row < first_row || last_row < 0 ||
                first_row > LAST_ROW) begin
               want.draw_rejected = 1'b1;
               refused++;
            end else begin
               y0 = (first_row < 0) ? 0 : first_row;
               y1 = (last_row > LAST_ROW) ? LAST_ROW : last_row;
               for (pg = y0 >> 3; pg <= (y1 >> 3); pg++) begin
                  mask = 8'hff;
                  // edge pages only take the rows the line covers
                  if (pg == (y0 >> 3)) mask &= 8'hff << (y0 % 8);
                  if (pg == (y1 >> 3)) mask &= 8'hff >> (7 - y1 % 8);
                  idx = pg * SCREEN_WIDTH + column;
                  pixels[idx] = (pixels[idx] & ~mask) | (pattern & mask);
               end
            end
         end
         pending_replies.push_back(want);
      endfunction

      function void check_reply(input logic [PAT_W-1:0] read_data,
                                input logic draw_rejected);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply beat, read_data=%h draw_rejected=%b",
                     $time, read_data, draw_rejected);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         checked++;
         if (read_data !== want.read_data) begin
            $display("%0t: read_data expected %h, got %h (reply %0d)",
                     $time, want.read_data, read_data, checked);
            mismatches++;
         end
         if (draw_rejected !== want.draw_rejected) begin
            $display("%0t: draw_rejected expected %b, got %b (reply %0d)",
                     $time, want.draw_rejected, draw_rejected, checked);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   pbvl_req_if req_ch ();
   pbvl_rsp_if rsp_ch ();

   framebuffer_mirror mirror = new();

   bit sender_calm   = 1'b0;   // no sender gaps while set
   int hold_left     = 0;      // remaining cycles of the long reply hold-off
   bit hold_done     = 1'b0;
   int cycle_count   = 0;
   logic [COL_W-1:0] recent_column = '0;

   page_buffer_vertical_line_fill_core #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .PAGE_COUNT   (PAGE_COUNT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Offers one request beat, after a random gap, and holds it until taken.
   task automatic send_request(input logic kind,
                               input logic [COL_W-1:0] column,
                               input logic signed [ROW_W-1:0] row_start,
                               input logic signed [ROW_W-1:0] row_end,
                               input logic [PAT_W-1:0] pattern,
                               input logic [RADDR_W-1:0] address);
      while (!sender_calm && $urandom_range(0, 99) < 11) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.column       <= column;
      req_ch.row_start    <= row_start;
      req_ch.row_end      <= row_end;
      req_ch.fill_pattern <= pattern;
      req_ch.read_address <= address;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      mirror.apply_request(kind, column, row_start, row_end, pattern, address);
   endtask

   // Unused fields get random values so their bits toggle too.
   task automatic draw_column(input logic [COL_W-1:0] column,
                              input logic signed [ROW_W-1:0] row_start,
                              input logic signed [ROW_W-1:0] row_end,
                              input logic [PAT_W-1:0] pattern);
      send_request(REQ_DRAW, column, row_start, row_end, pattern,
                   RADDR_W'($urandom));
      recent_column = column;
   endtask

   task automatic read_byte(input logic [RADDR_W-1:0] address);
      send_request(REQ_READ, COL_W'($urandom), ROW_W'($urandom), ROW_W'($urandom),
                   PAT_W'($urandom), address);
   endtask

   // -------------------------------------------------------------------------
   // Reply side: random stalls, a calm stretch, and one long hold-off that
   // lets the core fill up and stall its request port.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && mirror.checked >= 400) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 300;
         hold_done    <= 1'b1;
      end else if (mirror.checked >= 1000 && mirror.checked < 1300) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 11);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         mirror.check_reply(rsp_ch.read_data, rsp_ch.draw_rejected);
   end

   // Watchdog: covers the clearing pass after reset and all slow corners.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d replies still outstanding",
               $time, cycle_count, mirror.pending_replies.size());
      $display("Mismatches found");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int                      n;
      int                      mode;
      int                      s_row;
      int                      e_row;
      logic signed [ROW_W-1:0] s_fld;
      logic signed [ROW_W-1:0] e_fld;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.req_type     <= REQ_DRAW;
      req_ch.column       <= '0;
      req_ch.row_start    <= '0;
      req_ch.row_end      <= '0;
      req_ch.fill_pattern <= '0;
      req_ch.read_address <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // freshly cleared store, first and last byte
      read_byte(10'd0);
      read_byte(10'd1023);
      // full height line, then readback of top and bottom pages
      draw_column(7'd0, 8'sd0, 8'sd63, 8'hff);
      read_byte(10'd0);
      read_byte(10'd896);
      // clipped at both ends with the widest row values
      draw_column(7'd127, -8'sd128, 8'sd127, 8'ha5);
      read_byte(10'd1023);
      // refused: inverted, wholly above, wholly below
      draw_column(7'd5, 8'sd10, 8'sd9, 8'hff);
      draw_column(7'd5, -8'sd5, -8'sd1, 8'hff);
      draw_column(7'd5, 8'sd64, 8'sd100, 8'hff);
      draw_column(7'd5, 8'sd127, 8'sd127, 8'hff);
      draw_column(7'd5, -8'sd128, -8'sd128, 8'hff);
      // single rows at the very top and bottom, and one straddling a page edge
      draw_column(7'd5, 8'sd0, 8'sd0, 8'hff);
      draw_column(7'd5, 8'sd63, 8'sd63, 8'hff);
      draw_column(7'd5, 8'sd7, 8'sd8, 8'hff);
      // clear a few bits inside an already full byte
      draw_column(7'd0, 8'sd3, 8'sd5, 8'h00);
      // partial edge pages with whole pages in between
      draw_column(7'd0, 8'sd13, 8'sd50, 8'h5a);
      // last row kept when the end runs one past the bottom
      draw_column(7'd64, 8'sd63, 8'sd64, 8'h80);
      read_byte(10'd0);
      read_byte(10'd128);
      read_byte(10'd768);
      read_byte(10'd5);
      read_byte(10'd133);
      read_byte(10'd901);
      read_byte(10'd960);

      // random mix, mostly well-formed lines with some wild row values
      for (n = 0; n < RANDOM_BEATS; n++) begin
         sender_calm = (n >= 1000 && n < 1300);
         if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 1) == 0)
               read_byte({3'($urandom_range(0, 7)), recent_column});
            else
               read_byte(RADDR_W'($urandom));
         end else begin
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
               s_row = $urandom_range(0, 63);
               e_row = s_row + $urandom_range(0, 40);
            end else if (mode < 8) begin
               s_row = int'($urandom_range(0, 80)) - 12;
               e_row = int'($urandom_range(0, 80)) - 12;
            end else begin
               s_row = $urandom_range(0, 255);
               e_row = $urandom_range(0, 255);
            end
            s_fld = ROW_W'(s_row);
            e_fld = ROW_W'(e_row);
            draw_column(COL_W'($urandom), s_fld, e_fld, PAT_W'($urandom));
         end
      end
      sender_calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d draws (%0d refused) and %0d byte reads, %0d non-zero.",
               mirror.draws, mirror.refused, mirror.reads, mirror.lit_reads);
      $display("%0d reply beats checked in %0d cycles.", mirror.checked, cycle_count);
      if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
